// File: sv/pss_pkg.sv
package pss_pkg;

    localparam int MAX_THREADS = 16;
    localparam int PRIO_BITS   = 6;
    localparam int ID_W        = 4;
    localparam int IDX_W       = 4;
    localparam int CNT_W       = 5;
    localparam int TICK_W      = 63;
    localparam logic [7:0] SLICE_RESET = 8'd4;

    localparam logic [2:0] CMD_ADD   = 3'd0;
    localparam logic [2:0] CMD_SLEEP = 3'd1;
    localparam logic [2:0] CMD_TICK  = 3'd2;
    localparam logic [2:0] CMD_YIELD = 3'd3;
    localparam logic [2:0] CMD_SETP  = 3'd4;
    localparam logic [2:0] CMD_BLOCK = 3'd5;

    typedef struct packed {
        logic [ID_W-1:0]      id;
        logic [PRIO_BITS-1:0] prio;
        logic [PRIO_BITS-1:0] bprio;
    } t_entry;

    // queue unit request: insert or pop-head
    typedef struct packed {
        logic   put;
        logic   pop;
        t_entry ent;
    } t_qreq;

    typedef struct packed {
        logic                 busy;
        logic                 ok;
        logic [CNT_W-1:0]     fill;
        t_entry               head;
    } t_qsts;

endpackage

// File: sv/pss_queue.sv
// Sorted ready queue; one shift step per cycle.
module pss_queue import pss_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_qreq  i_req,
    output t_qsts  o_sts
);
    typedef enum logic [2:0] {
        Q_IDLE = 3'b001,
        Q_PUT  = 3'b010,
        Q_POP  = 3'b100
    } t_qstate;

    t_qstate          r_st, n_st;
    t_entry           r_mem [MAX_THREADS];
    logic [CNT_W-1:0] r_fill, n_fill;
    logic [CNT_W-1:0] r_k, n_k;
    t_entry           r_ent, n_ent;
    logic             r_ok, n_ok;

    always_comb begin
        n_st = r_st; n_fill = r_fill; n_k = r_k; n_ent = r_ent; n_ok = r_ok;
        case (r_st)
            Q_IDLE: begin
                if (i_req.put) begin
                    n_ent = i_req.ent;
                    if (r_fill >= CNT_W'(MAX_THREADS)) begin
                        n_ok = 1'b0;
                    end else begin
                        n_ok = 1'b1;
                        n_k  = r_fill;
                        n_st = Q_PUT;
                    end
                end else if (i_req.pop && r_fill != '0) begin
                    n_ok = 1'b1;
                    n_k  = CNT_W'(1);
                    n_st = Q_POP;
                end
            end
            Q_PUT: begin
                // walk from tail toward head, shifting lower-priority entries down
                if (r_k != '0 && r_mem[r_k[IDX_W-1:0] - 1'b1].prio < r_ent.prio) begin
                    n_k = r_k - 1'b1;
                end else begin
                    n_fill = r_fill + 1'b1;
                    n_st   = Q_IDLE;
                end
            end
            Q_POP: begin
                if (r_k >= r_fill) begin
                    n_fill = r_fill - 1'b1;
                    n_st   = Q_IDLE;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            default: n_st = Q_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= Q_IDLE;
            r_fill <= '0;
            r_ok   <= 1'b1;
        end else begin
            r_st   <= n_st;
            r_fill <= n_fill;
            r_ok   <= n_ok;
        end
        r_k   <= n_k;
        r_ent <= n_ent;
        if (r_st == Q_PUT) begin
            if (r_k != '0 && r_mem[r_k[IDX_W-1:0] - 1'b1].prio < r_ent.prio)
                r_mem[r_k[IDX_W-1:0]] <= r_mem[r_k[IDX_W-1:0] - 1'b1];
            else
                r_mem[r_k[IDX_W-1:0]] <= r_ent;
        end else if (r_st == Q_POP && r_k < r_fill) begin
            r_mem[r_k[IDX_W-1:0] - 1'b1] <= r_mem[r_k[IDX_W-1:0]];
        end
    end

    assign o_sts.busy = (r_st != Q_IDLE) || i_req.put || i_req.pop;
    assign o_sts.ok   = r_ok;
    assign o_sts.fill = r_fill;
    assign o_sts.head = r_mem[0];
endmodule

// File: sv/priority_sleep_scheduler.sv
// Priority scheduler with sleep table.
// Command channel: i_start with i_command/i_thread_id/i_prio/i_tick is
// accepted when o_busy is low; o_busy then stays high until the result.
// Each command gives one result, shown for one cycle with o_done high:
// running thread, its priority, idle flag, preempt request, woken count,
// ready count and full error.
// Order of work: an insert or a head pop shifts the sorted queue one entry per
// cycle; a tick command scans the sleep table entry by entry and inserts
// each woken thread into the ready queue. One command is handled at a time and
// the next one can be accepted in the o_done cycle.
// i_cfg_we writes the time slice (reset 4); write only while idle.
// Reset: queues empty, idle runs, slice counter zero. Nothing to set up.
// The receiver cannot stall; a result must be taken in its cycle.
module priority_sleep_scheduler import pss_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    output logic                 o_busy,
    input  logic [2:0]           i_command,
    input  logic [ID_W-1:0]      i_thread_id,
    input  logic [PRIO_BITS-1:0] i_prio,
    input  logic [TICK_W-1:0]    i_tick,
    input  logic                 i_cfg_we,
    input  logic [7:0]           i_cfg_wdata,
    output logic                 o_done,
    output logic [ID_W-1:0]      o_running_id,
    output logic [PRIO_BITS-1:0] o_running_prio,
    output logic                 o_running_idle,
    output logic                 o_preempt,
    output logic [CNT_W-1:0]     o_woken_count,
    output logic [CNT_W-1:0]     o_ready_count,
    output logic                 o_full_error
);
    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_DEC   = 10'b0000000010,
        S_QWAIT = 10'b0000000100, // wait for queue op, then next
        S_YPOP  = 10'b0000001000, // after yield or set-priority insert: pop head
        S_SCAN  = 10'b0000010000,
        S_SRD   = 10'b0000100000,
        S_SPUT  = 10'b0001000000,
        S_DISP  = 10'b0010000000,
        S_FIN   = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } t_state;

    typedef struct packed {
        logic [ID_W-1:0]      id;
        logic [TICK_W-1:0]    wake;
        logic [PRIO_BITS-1:0] prio;
        logic [PRIO_BITS-1:0] bprio;
    } t_slp;

    t_state r_st;
    t_state r_after;          // where S_QWAIT goes next
    logic [2:0]           r_cmd;
    logic [ID_W-1:0]      r_tid;
    logic [PRIO_BITS-1:0] r_p;
    logic [TICK_W-1:0]    r_tick;
    logic [7:0]           r_slice, r_ticks;
    logic [ID_W-1:0]      r_run_id;
    logic [PRIO_BITS-1:0] r_run_prio, r_run_bprio;
    logic                 r_idle, r_err, r_pre, r_done;
    logic [CNT_W-1:0]     r_woken, r_sfill, r_si, r_kept;
    t_slp                 r_smem [MAX_THREADS];
    t_slp                 r_srd;
    t_qreq                w_req;
    t_qsts                w_qs;
    t_entry               w_run;

    assign w_run = '{id: r_run_id, prio: r_run_prio, bprio: r_run_bprio};

    pss_queue u_queue (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_req), .o_sts(w_qs));

    always_comb begin
        w_req = '0;
        if (r_st == S_DEC) begin
            case (r_cmd)
                CMD_ADD: begin
                    w_req.put = 1'b1;
                    w_req.ent = '{id: r_tid, prio: r_p, bprio: r_p};
                end
                CMD_YIELD: begin
                    w_req.put = !r_idle;
                    w_req.ent = w_run;
                end
                CMD_SETP: begin
                    w_req.put = !r_idle && w_qs.fill != '0 &&
                                w_qs.head.prio > ((r_run_prio == r_run_bprio) ?
                                                  r_p : r_run_prio);
                    w_req.ent = '{id: r_run_id,
                                  prio: (r_run_prio == r_run_bprio) ? r_p : r_run_prio,
                                  bprio: r_p};
                end
                default: w_req = '0;
            endcase
        end else if (r_st == S_SPUT) begin
            w_req.put = 1'b1;
            w_req.ent = '{id: r_srd.id, prio: r_srd.prio, bprio: r_srd.bprio};
        end else if (r_st == S_DISP) begin
            w_req.pop = w_qs.fill != '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= S_IDLE;
            r_after     <= S_IDLE;
            r_slice     <= SLICE_RESET;
            r_ticks     <= '0;
            r_run_id    <= '0;
            r_run_prio  <= '0;
            r_run_bprio <= '0;
            r_idle      <= 1'b1;
            r_sfill     <= '0;
            r_done      <= 1'b0;
        end else begin
            r_done <= (r_st == S_OUT);
            if (i_cfg_we) r_slice <= i_cfg_wdata;
            case (r_st)
                S_IDLE: begin
                    if (i_start) begin
                        r_cmd  <= i_command;
                        r_tid  <= i_thread_id;
                        r_p    <= i_prio;
                        r_tick <= i_tick;
                        r_err  <= 1'b0;
                        r_woken <= '0;
                        r_st   <= S_DEC;
                    end
                end
                S_DEC: begin
                    case (r_cmd)
                        CMD_ADD: begin
                            r_after <= S_FIN;
                            r_st    <= S_QWAIT;
                        end
                        CMD_SLEEP: begin
                            if (r_idle) begin
                                r_st <= S_FIN;
                            end else if (r_sfill >= CNT_W'(MAX_THREADS)) begin
                                r_err <= 1'b1;
                                r_st  <= S_FIN;
                            end else begin
                                r_smem[r_sfill[IDX_W-1:0]] <= '{id: r_run_id,
                                    wake: r_tick, prio: r_run_prio,
                                    bprio: r_run_bprio};
                                r_sfill <= r_sfill + 1'b1;
                                r_st    <= S_DISP;
                            end
                        end
                        CMD_TICK: begin
                            if (!r_idle && r_ticks != 8'hFF) r_ticks <= r_ticks + 1'b1;
                            r_si   <= '0;
                            r_kept <= '0;
                            r_st   <= S_SCAN;
                        end
                        CMD_YIELD: begin
                            if (!r_idle) begin
                                r_after <= S_YPOP;
                                r_st    <= S_QWAIT;
                            end else begin
                                r_st <= S_FIN;
                            end
                        end
                        CMD_SETP: begin
                            if (!r_idle) begin
                                if (r_run_prio == r_run_bprio) r_run_prio <= r_p;
                                r_run_bprio <= r_p;
                                if (w_req.put) begin
                                    r_after <= S_YPOP;
                                    r_st    <= S_QWAIT;
                                end else begin
                                    r_st <= S_FIN;
                                end
                            end else begin
                                r_st <= S_FIN;
                            end
                        end
                        CMD_BLOCK: r_st <= r_idle ? S_FIN : S_DISP;
                        default: r_st <= S_FIN;
                    endcase
                end
                S_QWAIT: begin
                    if (!w_qs.busy) begin
                        if (!w_qs.ok) r_err <= 1'b1;
                        if (r_after == S_YPOP) r_st <= w_qs.ok ? S_DISP : S_FIN;
                        else if (r_after == S_SCAN) begin
                            if (w_qs.ok) r_woken <= r_woken + 1'b1;
                            else begin
                                r_smem[r_kept[IDX_W-1:0]] <= r_srd;
                                r_kept <= r_kept + 1'b1;
                            end
                            r_si <= r_si + 1'b1;
                            r_st <= S_SCAN;
                        end else r_st <= r_after;
                    end
                end
                S_SCAN: begin
                    if (r_si >= r_sfill) begin
                        r_sfill <= r_kept;
                        r_st    <= S_FIN;
                    end else begin
                        r_srd <= r_smem[r_si[IDX_W-1:0]];
                        r_st  <= S_SRD;
                    end
                end
                S_SRD: begin
                    if (r_tick >= r_srd.wake) begin
                        r_st <= S_SPUT;
                    end else begin
                        r_smem[r_kept[IDX_W-1:0]] <= r_srd;
                        r_kept <= r_kept + 1'b1;
                        r_si   <= r_si + 1'b1;
                        r_st   <= S_SCAN;
                    end
                end
                S_SPUT: begin
                    r_after <= S_SCAN;
                    r_st    <= S_QWAIT;
                end
                S_DISP: begin
                    // pop issued this cycle; head is still visible
                    r_ticks <= '0;
                    if (w_qs.fill == '0) begin
                        r_idle <= 1'b1; r_run_id <= '0;
                        r_run_prio <= '0; r_run_bprio <= '0;
                        r_st <= S_FIN;
                    end else begin
                        r_idle <= 1'b0;
                        r_run_id <= w_qs.head.id;
                        r_run_prio <= w_qs.head.prio;
                        r_run_bprio <= w_qs.head.bprio;
                        r_after <= S_FIN;
                        r_st <= S_QWAIT;
                    end
                end
                S_FIN: begin
                    if (r_idle && w_qs.fill != '0) r_st <= S_DISP;
                    else begin
                        r_pre <= !r_idle && ((w_qs.fill != '0 && w_qs.head.prio > r_run_prio)
                                 || r_ticks >= r_slice);
                        r_st  <= S_OUT;
                    end
                end
                S_OUT: begin
                    r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    assign o_busy         = r_st != S_IDLE;
    assign o_done         = r_done;
    assign o_running_id   = r_run_id;
    assign o_running_prio = r_run_prio;
    assign o_running_idle = r_idle;
    assign o_preempt      = r_pre;
    assign o_woken_count  = r_woken;
    assign o_ready_count  = w_qs.fill;
    assign o_full_error   = r_err;
endmodule

// File: sv/pss_checker.sv
module pss_checker import pss_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_start,
    input logic                 o_busy,
    input logic                 o_done,
    input logic [ID_W-1:0]      o_running_id,
    input logic [PRIO_BITS-1:0] o_running_prio,
    input logic                 o_running_idle,
    input logic                 o_preempt,
    input logic [CNT_W-1:0]     o_ready_count
);
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start && !o_busy |=> o_busy) else $error("busy not raised");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !o_busy) else $error("done while busy");
    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_running_idle |-> o_running_id == '0 && o_running_prio == '0 &&
        !o_preempt && o_ready_count == '0) else $error("idle with work");
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready_count <= CNT_W'(MAX_THREADS)) else $error("ready count overflow");
endmodule

bind priority_sleep_scheduler pss_checker u_pss_checker (.*);
